// ----- rtl/tvbb_pkg.sv -----
// ----------------------------------------------------------------------------
// tvbb_pkg: shared types and codes for the TMR voter / bang-bang control unit
// Health codes, action codes, drive encodings and the vote decision struct.
// ----------------------------------------------------------------------------
`default_nettype none

package tvbb_pkg;

    // Port widths fixed by the interface
    localparam int unsigned AVG_W  = 16;
    localparam int unsigned ERR_W  = 17;
    localparam int unsigned SAMPLE_WIDTH_DEF = 16;

    // Filter health codes
    typedef logic [1:0] t_code;
    localparam t_code CODE_DEAD     = 2'd0;
    localparam t_code CODE_OK       = 2'd1;
    localparam t_code CODE_DISAGREE = 2'd2;

    // Filter identifiers; identifier three writes nothing
    localparam logic [1:0] SRC_NONE = 2'd3;

    // Control action codes
    typedef logic [1:0] t_action;
    localparam t_action ACT_POS  = 2'd1;
    localparam t_action ACT_NEG  = 2'd2;
    localparam t_action ACT_ZERO = 2'd3;

    // Plant drive, two-bit signed
    localparam logic [1:0] DRV_POS  = 2'b01;
    localparam logic [1:0] DRV_NEG  = 2'b11;
    localparam logic [1:0] DRV_ZERO = 2'b00;

    typedef t_code [2:0] t_code_vec;

    // Vote decision handed from the voter to the datapath
    typedef struct packed {
        logic      alert;
        logic      use_err;
        logic      sel_second;
        t_code_vec codes;
    } t_vote;

    // Write one health code; later writes win
    function automatic t_code_vec set_code(input t_code_vec codes,
                                           input logic [1:0] id,
                                           input t_code code);
        t_code_vec res;
        res = codes;
        if (id != SRC_NONE) begin
            res[id] = code;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tvbb_vote.sv -----
// ----------------------------------------------------------------------------
// tvbb_vote: majority vote decision
// From the arrival flags, filter identifiers and the pairwise equality of
// the three samples, decides alert, filter health and which sample drives
// the error.
// ----------------------------------------------------------------------------
`default_nettype none

module tvbb_vote (
    input  wire logic [2:0]        i_got,   // effective arrival, slot order applied
    input  wire logic [2:0][1:0]   i_src,
    input  wire logic              i_eq12,
    input  wire logic              i_eq23,
    input  wire logic              i_eq13,
    output tvbb_pkg::t_vote        o_vote
);

    tvbb_pkg::t_vote w_vote;

    always_comb begin
        w_vote            = '0;
        w_vote.codes      = {3{tvbb_pkg::CODE_DEAD}};
        if (!i_got[0]) begin
            // nothing arrived
            w_vote.alert = 1'b1;
        end else if (!i_got[1]) begin
            // single message: its filter is alive
            w_vote.alert = 1'b1;
            w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[0], tvbb_pkg::CODE_OK);
        end else if (!i_got[2]) begin
            // two messages
            if (i_eq12) begin
                w_vote.use_err = 1'b1;
            end else begin
                w_vote.alert = 1'b1;
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[0],
                                                  tvbb_pkg::CODE_DISAGREE);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[1],
                                                  tvbb_pkg::CODE_DISAGREE);
            end
        end else begin
            // three messages
            if (i_eq12 && i_eq23) begin
                w_vote.use_err = 1'b1;
            end else if (i_eq12) begin
                w_vote.alert   = 1'b1;
                w_vote.use_err = 1'b1;
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[0], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[1], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[2],
                                                  tvbb_pkg::CODE_DISAGREE);
            end else if (i_eq23) begin
                w_vote.alert      = 1'b1;
                w_vote.use_err    = 1'b1;
                w_vote.sel_second = 1'b1;
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[2], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[1], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[0],
                                                  tvbb_pkg::CODE_DISAGREE);
            end else if (i_eq13) begin
                w_vote.alert   = 1'b1;
                w_vote.use_err = 1'b1;
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[0], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[2], tvbb_pkg::CODE_OK);
                w_vote.codes = tvbb_pkg::set_code(w_vote.codes, i_src[1],
                                                  tvbb_pkg::CODE_DISAGREE);
            end else begin
                w_vote.alert = 1'b1;
                w_vote.codes = {3{tvbb_pkg::CODE_DISAGREE}};
            end
        end
        // codes are reported only with an alert
        if (!w_vote.alert) begin
            w_vote.codes = {3{tvbb_pkg::CODE_DEAD}};
        end
    end

    assign o_vote = w_vote;

endmodule

`default_nettype wire

// ----- rtl/tmr_vote_bang_bang_control_unit.sv -----
// ----------------------------------------------------------------------------
// tmr_vote_bang_bang_control_unit: TMR majority voter with bang-bang control
// Four register stages lie between the accepted input transaction and the
// result: compare, vote, subtract, saturate/sign.
// Throughput: one transaction per cycle; each stage holds while the stage
// after it is full and stalled.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_vote_bang_bang_control_unit #(
    parameter int unsigned SAMPLE_WIDTH = tvbb_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_got_first,
    input  wire logic [1:0]                  i_src_first,
    input  wire logic [tvbb_pkg::AVG_W-1:0]  i_avg_first,
    input  wire logic                        i_got_second,
    input  wire logic [1:0]                  i_src_second,
    input  wire logic [tvbb_pkg::AVG_W-1:0]  i_avg_second,
    input  wire logic                        i_got_third,
    input  wire logic [1:0]                  i_src_third,
    input  wire logic [tvbb_pkg::AVG_W-1:0]  i_avg_third,
    input  wire logic [tvbb_pkg::AVG_W-1:0]  i_setpoint,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_action,
    output logic signed [1:0]                o_drive,
    output logic                             o_alert,
    output logic [1:0]                       o_code_zero,
    output logic [1:0]                       o_code_one,
    output logic [1:0]                       o_code_two,
    output logic signed [tvbb_pkg::ERR_W-1:0] o_error_value
);

    localparam int unsigned SW = SAMPLE_WIDTH;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Sample masking or zero extension to SAMPLE_WIDTH bits
    // ------------------------------------------------------------------
    logic [SW-1:0] w_a1, w_a2, w_a3, w_ref;

    if (SW <= tvbb_pkg::AVG_W) begin : g_narrow
        assign w_a1  = i_avg_first[SW-1:0];
        assign w_a2  = i_avg_second[SW-1:0];
        assign w_a3  = i_avg_third[SW-1:0];
        assign w_ref = i_setpoint[SW-1:0];
    end else begin : g_wide
        assign w_a1  = {{(SW-tvbb_pkg::AVG_W){1'b0}}, i_avg_first};
        assign w_a2  = {{(SW-tvbb_pkg::AVG_W){1'b0}}, i_avg_second};
        assign w_a3  = {{(SW-tvbb_pkg::AVG_W){1'b0}}, i_avg_third};
        assign w_ref = {{(SW-tvbb_pkg::AVG_W){1'b0}}, i_setpoint};
    end

    // ------------------------------------------------------------------
    // Stage 1: slot order and pairwise compares
    // ------------------------------------------------------------------
    logic [2:0]      r_got1;
    logic [2:0][1:0] r_src1;
    logic [SW-1:0]   r_a1_1, r_a2_1, r_ref1;
    logic            r_eq12, r_eq23, r_eq13;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            // a slot counts only after every earlier slot arrived
            r_got1[0] <= i_got_first;
            r_got1[1] <= i_got_first && i_got_second;
            r_got1[2] <= i_got_first && i_got_second && i_got_third;
            r_src1    <= {i_src_third, i_src_second, i_src_first};
            r_a1_1    <= w_a1;
            r_a2_1    <= w_a2;
            r_ref1    <= w_ref;
            r_eq12    <= (w_a1 == w_a2);
            r_eq23    <= (w_a2 == w_a3);
            r_eq13    <= (w_a1 == w_a3);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: vote decision and voted sample select
    // ------------------------------------------------------------------
    tvbb_pkg::t_vote w_vote;

    tvbb_vote u_vote (
        .i_got  (r_got1),
        .i_src  (r_src1),
        .i_eq12 (r_eq12),
        .i_eq23 (r_eq23),
        .i_eq13 (r_eq13),
        .o_vote (w_vote)
    );

    logic [SW-1:0]       r_voted2, r_ref2;
    logic                r_use2, r_alert2;
    tvbb_pkg::t_code_vec r_codes2;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_voted2 <= w_vote.sel_second ? r_a2_1 : r_a1_1;
            r_ref2   <= r_ref1;
            r_use2   <= w_vote.use_err;
            r_alert2 <= w_vote.alert;
            r_codes2 <= w_vote.codes;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: error subtract
    // ------------------------------------------------------------------
    logic signed [SW:0]  r_err3;
    logic                r_alert3;
    tvbb_pkg::t_code_vec r_codes3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            if (r_use2) begin
                r_err3 <= $signed({1'b0, r_ref2}) - $signed({1'b0, r_voted2});
            end else begin
                r_err3 <= '0;
            end
            r_alert3 <= r_alert2;
            r_codes3 <= r_codes2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sign to action/drive, saturate to the output width
    // ------------------------------------------------------------------
    logic signed [tvbb_pkg::ERR_W-1:0] w_err_sat;
    logic                              w_pos, w_neg;

    assign w_neg = r_err3[SW];
    assign w_pos = !r_err3[SW] && (r_err3 != '0);

    if (SW + 1 <= tvbb_pkg::ERR_W) begin : g_fit
        assign w_err_sat = tvbb_pkg::ERR_W'(r_err3);
    end else begin : g_sat
        localparam logic signed [SW:0] ERR_HI =
            $signed({{(SW-tvbb_pkg::AVG_W){1'b0}}, 17'h0FFFF});
        localparam logic signed [SW:0] ERR_LO =
            $signed({{(SW-tvbb_pkg::AVG_W){1'b1}}, 17'h10000});
        always_comb begin
            if (r_err3 > ERR_HI) begin
                w_err_sat = ERR_HI[tvbb_pkg::ERR_W-1:0];
            end else if (r_err3 < ERR_LO) begin
                w_err_sat = ERR_LO[tvbb_pkg::ERR_W-1:0];
            end else begin
                w_err_sat = r_err3[tvbb_pkg::ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            if (w_pos) begin
                o_action <= tvbb_pkg::ACT_POS;
                o_drive  <= tvbb_pkg::DRV_POS;
            end else if (w_neg) begin
                o_action <= tvbb_pkg::ACT_NEG;
                o_drive  <= tvbb_pkg::DRV_NEG;
            end else begin
                o_action <= tvbb_pkg::ACT_ZERO;
                o_drive  <= tvbb_pkg::DRV_ZERO;
            end
            o_alert       <= r_alert3;
            o_code_zero   <= r_codes3[0];
            o_code_one    <= r_codes3[1];
            o_code_two    <= r_codes3[2];
            o_error_value <= w_err_sat;
        end
    end

    assign o_valid = r_v4;

endmodule

`default_nettype wire
